@@ rtl/apws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_pkg
// Shared types and constants of the anchored pattern window search.
// ----------------------------------------------------------------------------
package apws_pkg;

	localparam int PAT_BYTES = 16;
	localparam int LEN_W     = 5;
	localparam int MODE_W    = 2;
	localparam int COUNT_W   = 32;
	localparam int OUT_POS_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_ANY        = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LINE_END   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd4;

	typedef struct packed {
		logic [63:0]        pattern_low;
		logic [63:0]        pattern_high;
		logic [LEN_W-1:0]   pattern_len;
		logic [MODE_W-1:0]  search_mode;
		logic [31:0]        start_offset;
	} cfg_t;

endpackage

@@ rtl/apws_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_cfg_regs
// Configuration register file: pattern, length, mode and start offset.
// ----------------------------------------------------------------------------
module apws_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [apws_pkg::CFG_DAT_W-1:0] cfg_data,
	output apws_pkg::cfg_t                 cfg
);

	apws_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				apws_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				apws_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				apws_pkg::REG_PATTERN_LEN: begin
					cfg_q.pattern_len <= cfg_data[apws_pkg::LEN_W-1:0];
				end
				apws_pkg::REG_SEARCH_MODE: begin
					cfg_q.search_mode <= cfg_data[apws_pkg::MODE_W-1:0];
				end
				apws_pkg::REG_START_OFFSET: begin
					cfg_q.start_offset <= cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/apws_window_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_window_cmp
// Parallel compare of the newest pattern_len window bytes with the pattern.
// ----------------------------------------------------------------------------
module apws_window_cmp #(
	parameter int MAX_PATTERN = 16
) (
	input  logic [MAX_PATTERN*8-1:0]       win,
	input  logic [63:0]                    pattern_low,
	input  logic [63:0]                    pattern_high,
	input  logic [apws_pkg::LEN_W-1:0]     pattern_len,
	input  logic                           len_ok,
	output logic                           equal
);

	logic [apws_pkg::PAT_BYTES*8-1:0] pat;
	logic [MAX_PATTERN-1:0]           byte_ok;

	assign pat = {pattern_high, pattern_low};

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_byte
		logic                         in_use;
		logic [apws_pkg::LEN_W-1:0]   idx;
		logic [7:0]                   pb;

		assign in_use = j < int'(pattern_len);
		assign idx    = pattern_len - apws_pkg::LEN_W'(j) - apws_pkg::LEN_W'(1);
		assign pb     = idx[apws_pkg::LEN_W-1] ? 8'h00 : pat[8*idx[3:0] +: 8];
		assign byte_ok[j] = !in_use || (win[8*j +: 8] == pb);
	end

	assign equal = len_ok && (&byte_ok);

endmodule

@@ rtl/anchored_pattern_window_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchored_pattern_window_search_core
// Streaming fixed-string search with line-start and line-end anchoring.
// Each byte is registered in the input stage; its result is registered when that stage advances.
// Throughput: one byte per cycle while data_stall is low, set by the combinational window compare.
// data_stall rises only while a result waits and result_stall is high.
// Reset clears the window, byte count, done flag and valid flags, and re-arms the anchors.
// ----------------------------------------------------------------------------
module anchored_pattern_window_search_core #(
	parameter int MAX_PATTERN = 16,
	parameter int POS_WIDTH   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [apws_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           data_valid,
	output logic                           data_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           found,
	output logic [apws_pkg::OUT_POS_W-1:0] position
);

	localparam int CW = apws_pkg::COUNT_W;

	apws_pkg::cfg_t cfg;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [7:0]    win_q [MAX_PATTERN];
	logic [CW-1:0] seen_q;
	logic [7:0]    bbw_q;
	logic          at_start_q;
	logic          done_q;

	logic                           out_valid_q;
	logic                           found_q;
	logic [apws_pkg::OUT_POS_W-1:0] position_q;

	logic                     advance;
	logic                     len_ok;
	logic [MAX_PATTERN*8-1:0] win_old;
	logic [MAX_PATTERN*8-1:0] win_new;
	logic                     eq_old;
	logic                     eq_new;
	logic [CW-1:0]            seen_new;
	logic                     prev_ge;
	logic                     new_ge;
	logic [7:0]               out_byte;
	logic                     slide;
	logic [7:0]               bbw_next;
	logic                     at_start_next;
	logic                     take;
	logic                     hit_nl;
	logic                     hit_win;
	logic                     hit;
	logic [CW-1:0]            count;
	logic [POS_WIDTH-1:0]     pos;

	apws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign data_stall = valid_s1 && !advance;

	assign len_ok = (cfg.pattern_len != '0) && (int'(cfg.pattern_len) <= MAX_PATTERN);

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_old[8*k +: 8] = win_q[k];
		end
		win_new[7:0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_new[8*k +: 8] = win_q[k-1];
		end
	end

	apws_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_old (
		.win          (win_old),
		.pattern_low  (cfg.pattern_low),
		.pattern_high (cfg.pattern_high),
		.pattern_len  (cfg.pattern_len),
		.len_ok       (len_ok),
		.equal        (eq_old)
	);

	apws_window_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_cmp_new (
		.win          (win_new),
		.pattern_low  (cfg.pattern_low),
		.pattern_high (cfg.pattern_high),
		.pattern_len  (cfg.pattern_len),
		.len_ok       (len_ok),
		.equal        (eq_new)
	);

	always_comb begin
		out_byte = 8'h00;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (k == int'(cfg.pattern_len) - 1) begin
				out_byte = win_q[k];
			end
		end
	end

	assign seen_new = (seen_q == apws_pkg::COUNT_MAX) ? seen_q : seen_q + CW'(1);
	assign prev_ge  = seen_q >= CW'(cfg.pattern_len);
	assign new_ge   = seen_new >= CW'(cfg.pattern_len);

	assign slide         = len_ok && prev_ge;
	assign bbw_next      = slide ? out_byte : bbw_q;
	assign at_start_next = slide ? 1'b0 : at_start_q;

	always_comb begin
		case (cfg.search_mode)
			apws_pkg::MODE_ANY:        take = 1'b1;
			apws_pkg::MODE_LINE_START: take = at_start_next || (bbw_next == apws_pkg::NEWLINE);
			apws_pkg::MODE_LINE_END:   take = last_s1;
			default:                   take = 1'b0;
		endcase
	end

	assign hit_nl  = (cfg.search_mode == apws_pkg::MODE_LINE_END) && prev_ge
		&& (byte_s1 == apws_pkg::NEWLINE) && eq_old;
	assign hit_win = !hit_nl && new_ge && eq_new && take;
	assign hit     = hit_nl || hit_win;

	assign count = hit_nl ? seen_q : seen_new;
	assign pos   = POS_WIDTH'(cfg.start_offset) + POS_WIDTH'(count)
		- POS_WIDTH'(cfg.pattern_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && !data_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= 8'h00;
			end
			seen_q     <= '0;
			bbw_q      <= 8'h00;
			at_start_q <= 1'b1;
			done_q     <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					win_q[k] <= 8'h00;
				end
				seen_q     <= '0;
				bbw_q      <= 8'h00;
				at_start_q <= 1'b1;
				done_q     <= 1'b0;
			end else if (!done_q) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					win_q[k] <= win_new[8*k +: 8];
				end
				seen_q     <= seen_new;
				bbw_q      <= bbw_next;
				at_start_q <= at_start_next;
				done_q     <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !done_q && (hit || last_s1);
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q    <= hit;
			position_q <= hit ? apws_pkg::OUT_POS_W'(pos) : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign found        = found_q;
	assign position     = position_q;

endmodule

@@ rtl/apws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_checker
// Port-level checks of the search core, bound to the core module.
// ----------------------------------------------------------------------------
module apws_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           data_stall,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic                           found,
	input  logic [apws_pkg::OUT_POS_W-1:0] position
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(found) && $stable(position))
		else $error("result changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> position == '0)
		else $error("not-found result carries a nonzero position");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!data_stall))
		else $error("result appeared while the input side was stalled");

endmodule

bind anchored_pattern_window_search_core apws_checker u_apws_checker (.*);
